>>> design/jsvi_pkg.sv
// Package for the joint slew and velocity integrator: widths, codes, types.
package jsvi_pkg;

    localparam int JOINT_CNT_DEF  = 8;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OP_W     = 3;
    localparam int JOINT_W  = 3;
    localparam int IO_VAL_W = 32;
    localparam int ET_W     = 16;
    localparam int STEP_W   = 31;
    localparam int JIU_W    = 4;
    localparam int CFG_A_W  = 1;

    localparam int S_TDATA_W = 56;  // joint, value, elapsed_time, padded
    localparam int M_TDATA_W = 40;  // joint_index, position, padded

    localparam logic [CFG_A_W-1:0] REG_MAX_STEP     = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_JOINTS_IN_USE = 1'd1;

    localparam logic [STEP_W-1:0] MAX_STEP_RST = 31'd66;
    localparam logic [JIU_W-1:0]  JIU_RST      = 4'd8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_SET_GOAL = 3'd1,
        OP_SET_VEL  = 3'd2,
        OP_PRESET   = 3'd3,
        OP_READ     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT
    } t_state;

    // per-cell control: ring shift and the three joint-addressed writes
    typedef struct packed {
        logic shift;
        logic wr_pos;
        logic wr_goal;
        logic wr_vel;
    } t_cell_ctl;

endpackage

>>> design/jsvi_cell.sv
// One joint cell: position, goal and velocity, shifting toward the ring head.
module jsvi_cell
    import jsvi_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cell_ctl                    i_ctl,
    input  logic signed [VALUE_BITS-1:0] i_nxt_pos,
    input  logic signed [VALUE_BITS-1:0] i_nxt_goal,
    input  logic signed [VALUE_BITS-1:0] i_nxt_vel,
    input  logic signed [VALUE_BITS-1:0] i_wr_value,
    output logic signed [VALUE_BITS-1:0] o_pos,
    output logic signed [VALUE_BITS-1:0] o_goal,
    output logic signed [VALUE_BITS-1:0] o_vel
);

    logic signed [VALUE_BITS-1:0] r_pos, r_goal, r_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_goal <= '0;
            r_vel  <= '0;
        end else if (i_ctl.shift) begin
            r_pos  <= i_nxt_pos;
            r_goal <= i_nxt_goal;
            r_vel  <= i_nxt_vel;
        end else begin
            if (i_ctl.wr_pos)  r_pos  <= i_wr_value;
            if (i_ctl.wr_goal) r_goal <= i_wr_value;
            if (i_ctl.wr_vel)  r_vel  <= i_wr_value;
        end
    end

    assign o_pos  = r_pos;
    assign o_goal = r_goal;
    assign o_vel  = r_vel;

endmodule

>>> design/jsvi_update.sv
// Update unit at the ring head: registered velocity product, slew clamp, saturation.
module jsvi_update
    import jsvi_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_mul_en,
    input  logic                         i_vmode,
    input  logic [STEP_W-1:0]            i_max_step,
    input  logic [ET_W-1:0]              i_et,
    input  logic signed [VALUE_BITS-1:0] i_pos,
    input  logic signed [VALUE_BITS-1:0] i_goal,
    input  logic signed [VALUE_BITS-1:0] i_vel,
    output logic signed [VALUE_BITS-1:0] o_new_pos
);

    localparam int PW = VALUE_BITS + ET_W + 1;                        // product
    localparam int DW = (VALUE_BITS + 2 > STEP_W + 2) ? VALUE_BITS + 2 : STEP_W + 2;
    localparam int SW = (VALUE_BITS + 3 > DW) ? VALUE_BITS + 3 : DW;  // pre-sat sum
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (VALUE_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    logic signed [PW-1:0]         r_prod;
    logic signed [PW:0]           rnd;
    logic signed [PW-ET_W:0]      delta;
    logic signed [DW-1:0]         diff, lim, step;
    logic signed [SW-1:0]         sum;

    // velocity times elapsed time, Q16.32
    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= PW'(i_vel) * PW'($signed({1'b0, i_et}));
        end
    end

    always_comb begin
        rnd   = (PW+1)'(r_prod) + (PW+1)'(32768);
        delta = (PW-ET_W+1)'(rnd >>> ET_W);      // round to Q16.16, ties up
        diff  = DW'(i_goal) - DW'(i_pos);
        lim   = DW'($signed({1'b0, i_max_step}));
        if (diff > lim) begin
            step = lim;
        end else if (diff < -lim) begin
            step = -lim;
        end else begin
            step = diff;
        end
        if (i_vmode) begin
            sum = SW'(i_pos) + SW'(delta);
        end else begin
            sum = SW'(i_pos) + SW'(step);
        end
        if (sum > MAXV) begin
            o_new_pos = VALUE_BITS'(MAXV);
        end else if (sum < MINV) begin
            o_new_pos = VALUE_BITS'(MINV);
        end else begin
            o_new_pos = VALUE_BITS'(sum);
        end
    end

endmodule

>>> design/joint_slew_and_velocity_integrator.sv
// Top level of the joint slew limiter / velocity integrator with its sequencer.
//
// Holds position, goal and velocity for JOINT_CNT joints in a ring of cells, plus a
// global mode flag. Input beats carry the opcode in tuser: tick, set goal, set velocity,
// preset position, read positions. Set and preset beats give no output; set goal
// selects position mode, set velocity selects velocity mode, and a joint index at
// or beyond JOINT_CNT is ignored. A tick or read rotates the whole ring once through
// the update unit at the head, each joint slot passing a product register state
// and then an update-and-shift state, which waits on a stalled output for a joint
// in use. The block is busy for the whole pass, and the input is not ready
// during that time. Joints below joints_in_use (zero taken as one, clipped to
// JOINT_CNT) are updated on a tick and reported in order from joint 0, one output
// beat each, tlast on the final one; the remaining joints pass the head unchanged.
// Position mode moves each joint toward its goal by at most max_step; velocity mode
// adds velocity * elapsed_time rounded to Q16.16. Positions saturate at the signed
// VALUE_BITS range. Control and joint state reset directly; there is no clearing pass.
// Write configuration (max_step, joints_in_use) only while idle; nothing enforces it.
module joint_slew_and_velocity_integrator
    import jsvi_pkg::*;
#(
    parameter int JOINT_CNT  = JOINT_CNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [2:0] joint, [34:3] value,
                                                // [50:35] elapsed_time, rest zero
    input  logic [OP_W-1:0]      s_axis_tuser,  // [2:0] opcode
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [2:0] joint_index, [34:3] position,
                                                // rest zero
    output logic                 m_axis_tlast,  // last
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_A_W-1:0]   i_cfg_addr,
    input  logic [STEP_W-1:0]    i_cfg_wdata
);

    localparam int IW = (JOINT_CNT > 1) ? $clog2(JOINT_CNT) : 1;
    localparam int CW = $clog2(JOINT_CNT + 1);

    // config and mode
    logic [STEP_W-1:0] r_max_step;
    logic [JIU_W-1:0]  r_jiu;
    logic              r_vmode;

    // item context
    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_n;
    logic              r_is_tick;
    logic [ET_W-1:0]   r_et;

    // output register
    logic                r_out_valid;
    logic [JOINT_W-1:0]  r_out_joint;
    logic [IO_VAL_W-1:0] r_out_pos;
    logic                r_out_last;

    // input fields
    t_op                        in_op;
    logic [JOINT_W-1:0]         in_joint;
    logic [IO_VAL_W-1:0]        in_value;
    logic [ET_W-1:0]            in_et;
    logic [63:0]                raw_value;
    logic signed [VALUE_BITS-1:0] wr_value;
    logic                       accept_in;
    logic                       joint_ok;
    logic                       in_report;
    logic [31:0]                act32;

    // ring
    logic signed [VALUE_BITS-1:0] c_pos  [JOINT_CNT];
    logic signed [VALUE_BITS-1:0] c_goal [JOINT_CNT];
    logic signed [VALUE_BITS-1:0] c_vel  [JOINT_CNT];
    logic signed [VALUE_BITS-1:0] tail_pos;
    logic signed [VALUE_BITS-1:0] upd_pos;
    logic [63:0]                  head_ext;

    // sequencer controls
    logic out_free;
    logic active;
    logic idx_last;
    logic mul_en;
    logic shift;
    logic load_out;

    assign in_op     = t_op'(s_axis_tuser);
    assign in_joint  = s_axis_tdata[2:0];
    assign in_value  = s_axis_tdata[34:3];
    assign in_et     = s_axis_tdata[50:35];
    assign raw_value = {32'd0, in_value};
    assign wr_value  = raw_value[VALUE_BITS-1:0];

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign joint_ok  = {29'd0, in_joint} < 32'(JOINT_CNT);
    assign in_report = (in_op == OP_TICK) || (in_op == OP_READ);

    // active joint count: zero reads as one, clipped to the ring length
    always_comb begin
        if (r_jiu == '0) begin
            act32 = 32'd1;
        end else if ({28'd0, r_jiu} > 32'(JOINT_CNT)) begin
            act32 = 32'(JOINT_CNT);
        end else begin
            act32 = {28'd0, r_jiu};
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;
    assign active   = CW'(r_idx) < r_n;
    assign idx_last = r_idx == IW'(JOINT_CNT - 1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept_in && in_report) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!active || out_free) begin
                    n_state = idx_last ? ST_IDLE : ST_MUL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mul_en        = 1'b0;
        shift         = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_MUL:  mul_en = 1'b1;
            ST_EMIT: begin
                shift    = !active || out_free;
                load_out = active && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_n         <= '0;
            r_is_tick   <= 1'b0;
            r_max_step  <= MAX_STEP_RST;
            r_jiu       <= JIU_RST;
            r_vmode     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_MAX_STEP:      r_max_step <= i_cfg_wdata;
                    REG_JOINTS_IN_USE: r_jiu      <= i_cfg_wdata[JIU_W-1:0];
                    default: ;
                endcase
            end
            if (accept_in) begin
                r_idx     <= '0;
                r_n       <= CW'(act32);
                r_is_tick <= in_op == OP_TICK;
                if (joint_ok && in_op == OP_SET_GOAL) r_vmode <= 1'b0;
                if (joint_ok && in_op == OP_SET_VEL)  r_vmode <= 1'b1;
            end
            if (shift && !idx_last) r_idx <= r_idx + IW'(1);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // elapsed time and output payload; a tick reports the freshly updated position
    assign head_ext = 64'($unsigned(tail_pos));

    always_ff @(posedge i_clk) begin
        if (accept_in) r_et <= in_et;
        if (load_out) begin
            r_out_joint <= JOINT_W'(r_idx);
            r_out_pos   <= head_ext[IO_VAL_W-1:0];
            r_out_last  <= (CW+1)'(r_idx) + (CW+1)'(1) == (CW+1)'(r_n);
        end
    end

    jsvi_update #(
        .VALUE_BITS(VALUE_BITS)
    ) u_update (
        .i_clk      (i_clk),
        .i_mul_en   (mul_en),
        .i_vmode    (r_vmode),
        .i_max_step (r_max_step),
        .i_et       (r_et),
        .i_pos      (c_pos[0]),
        .i_goal     (c_goal[0]),
        .i_vel      (c_vel[0]),
        .o_new_pos  (upd_pos)
    );

    // head re-enters at the tail, updated only on a tick for joints in use
    assign tail_pos = (r_is_tick && active) ? upd_pos : c_pos[0];

    for (genvar k = 0; k < JOINT_CNT; k++) begin : g_cell
        t_cell_ctl                    ctl;
        logic signed [VALUE_BITS-1:0] nxt_pos, nxt_goal, nxt_vel;
        logic                         sel;

        assign sel = accept_in && joint_ok && ({29'd0, in_joint} == 32'(k));
        assign ctl.shift   = shift;
        assign ctl.wr_pos  = sel && in_op == OP_PRESET;
        assign ctl.wr_goal = sel && (in_op == OP_PRESET || in_op == OP_SET_GOAL);
        assign ctl.wr_vel  = sel && in_op == OP_SET_VEL;

        if (k == JOINT_CNT - 1) begin : g_tail
            assign nxt_pos  = tail_pos;
            assign nxt_goal = c_goal[0];
            assign nxt_vel  = c_vel[0];
        end else begin : g_mid
            assign nxt_pos  = c_pos[k+1];
            assign nxt_goal = c_goal[k+1];
            assign nxt_vel  = c_vel[k+1];
        end

        jsvi_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_nxt_pos  (nxt_pos),
            .i_nxt_goal (nxt_goal),
            .i_nxt_vel  (nxt_vel),
            .i_wr_value (wr_value),
            .o_pos      (c_pos[k]),
            .o_goal     (c_goal[k]),
            .o_vel      (c_vel[k])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_pos, r_out_joint};
    assign m_axis_tlast  = r_out_last;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the joint slew limiter / velocity integrator.
`timescale 1ns / 100ps

module tb_top;
    import jsvi_pkg::*;

    localparam int NUM_J       = JOINT_CNT_DEF;
    localparam int TDATA_PAD   = S_TDATA_W - (JOINT_W + IO_VAL_W + ET_W);
    localparam int QUIET_CYC   = 2 * NUM_J + 8;  // one full ring pass plus margin
    localparam int STALL_LIMIT = 2000;           // cycles with no accepted beat or register write before giving up
    localparam int N_PHASE     = 6;
    localparam int BEATS_PER_PHASE = 26;

    localparam logic [IO_VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [IO_VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [STEP_W-1:0]   STEP_MAX = 31'h7FFF_FFFF;

    // opcodes past OP_READ: the block drops them
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [JOINT_W-1:0]  jnt;
        logic [IO_VAL_W-1:0] val;
        logic [ET_W-1:0]     et;
    } t_cmd;

    typedef struct packed {
        logic [JOINT_W-1:0]  idx;
        logic [IO_VAL_W-1:0] pos;
        logic                last;
    } t_report;

    typedef enum bit {ROW_BEAT, ROW_LIMITS} t_row_kind;

    // Directed row: either one input beat, or a write of both registers.
    // A pinned row carries a hand-typed position for one reported joint.
    typedef struct packed {
        t_row_kind           kind;
        t_cmd                cmd;
        logic                pin;
        logic [JOINT_W-1:0]  pin_jnt;
        logic [IO_VAL_W-1:0] pin_pos;
        logic [STEP_W-1:0]   lim_step;
        logic [JIU_W-1:0]    lim_count;
    } t_dir_row;

    function automatic t_dir_row beat_row(logic [OP_W-1:0] op, logic [JOINT_W-1:0] j,
                                          logic [IO_VAL_W-1:0] v, logic [ET_W-1:0] et);
        t_dir_row r;
        r = '0;
        r.kind = ROW_BEAT;
        r.cmd  = '{op: op, jnt: j, val: v, et: et};
        return r;
    endfunction

    function automatic t_dir_row pinned_row(logic [OP_W-1:0] op, logic [ET_W-1:0] et,
                                            logic [JOINT_W-1:0] pj,
                                            logic [IO_VAL_W-1:0] pp);
        t_dir_row r;
        r = beat_row(op, '0, '0, et);
        r.pin     = 1'b1;
        r.pin_jnt = pj;
        r.pin_pos = pp;
        return r;
    endfunction

    function automatic t_dir_row limits_row(logic [STEP_W-1:0] step, logic [JIU_W-1:0] cnt);
        t_dir_row r;
        r = '0;
        r.kind      = ROW_LIMITS;
        r.lim_step  = step;
        r.lim_count = cnt;
        return r;
    endfunction

    // Directed part. Runs from reset: max_step 66, all eight joints in use.
    localparam int N_DIR = 29;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        pinned_row(OP_READ, 16'h0000, 3'd0, 32'd0),          // reset state reads zero
        pinned_row(OP_TICK, 16'hFFFF, 3'd7, 32'd0),          // goals zero: nothing moves
        beat_row(OP_SET_GOAL, 3'd0, VAL_MAX, 16'h0000),
        beat_row(OP_SET_GOAL, 3'd7, VAL_MIN, 16'h0000),
        pinned_row(OP_TICK, 16'h0000, 3'd0, 32'd66),         // one max_step up
        pinned_row(OP_TICK, 16'h0000, 3'd7, 32'hFFFF_FF7C),  // two steps down: -132
        beat_row(OP_PRESET, 3'd0, 32'h7FFF_FFF0, 16'h0000),  // moves goal as well
        beat_row(OP_SET_GOAL, 3'd0, VAL_MAX, 16'h0000),
        pinned_row(OP_TICK, 16'h0000, 3'd0, VAL_MAX),        // short final step
        beat_row(OP_PRESET, 3'd1, VAL_MIN, 16'h0000),
        beat_row(OP_SET_VEL, 3'd0, VAL_MAX, 16'h0000),       // velocity mode from here
        beat_row(OP_SET_VEL, 3'd1, VAL_MIN, 16'h0000),
        pinned_row(OP_TICK, 16'hFFFF, 3'd1, VAL_MIN),        // both ends saturate
        beat_row(OP_SET_VEL, 3'd3, 32'h0000_8000, 16'h0000),
        beat_row(OP_SET_VEL, 3'd4, 32'hFFFF_8000, 16'h0000),
        pinned_row(OP_TICK, 16'h0001, 3'd3, 32'd1),          // +half rounds up
        pinned_row(OP_READ, 16'h0000, 3'd4, 32'd0),          // -half rounds to zero
        beat_row(OP_FIRST_UNUSED, 3'd2, 32'h1234_5678, 16'h55AA),
        beat_row(OP_LAST_UNUSED, 3'd5, 32'hEDCB_A987, 16'hAA55),
        beat_row(OP_SET_GOAL, 3'd5, 32'h0001_0000, 16'h0000), // back to position mode
        pinned_row(OP_TICK, 16'hFFFF, 3'd5, 32'd66),         // elapsed time ignored
        limits_row(31'd66, 4'd0),                            // zero joints means one
        pinned_row(OP_READ, 16'h0000, 3'd0, VAL_MAX),
        limits_row(31'd0, 4'd15),                            // count clipped to eight
        pinned_row(OP_TICK, 16'h1234, 3'd5, 32'd66),         // zero step: frozen
        limits_row(STEP_MAX, 4'd8),
        beat_row(OP_PRESET, 3'd6, VAL_MIN, 16'h0000),
        beat_row(OP_SET_GOAL, 3'd6, VAL_MAX, 16'h0000),
        pinned_row(OP_TICK, 16'h0000, 3'd6, 32'hFFFF_FFFF)   // min + max step = -1
    };

    // DUT ports; the inputs are known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [2:0] joint, [34:3] value,
                                               // [50:35] elapsed_time, rest zero
    logic [OP_W-1:0]      s_axis_tuser  = '0;  // [2:0] opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [2:0] joint_index, [34:3] position
    logic                 m_axis_tlast;        // last
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_A_W-1:0]   i_cfg_addr    = '0;
    logic [STEP_W-1:0]    i_cfg_wdata   = '0;

    joint_slew_and_velocity_integrator dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Shadow copy of the joint state and the two limits
    logic signed [IO_VAL_W-1:0] jp_pos  [NUM_J];
    logic signed [IO_VAL_W-1:0] jp_goal [NUM_J];
    logic signed [IO_VAL_W-1:0] jp_vel  [NUM_J];
    bit                         jp_vel_mode;
    logic [STEP_W-1:0]          lim_step;
    logic [JIU_W-1:0]           lim_count;

    t_report report_q [$];     // positions still to come out, oldest first
    int      n_fail       = 0;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;
    int      quiet_cycles = 0;

    function automatic longint clamp_q16(longint x);
        if (x > longint'(VAL_MAX)) return longint'(VAL_MAX);
        if (x < -longint'(VAL_MAX) - 1) return -longint'(VAL_MAX) - 1;
        return x;
    endfunction

    // Apply one accepted command to the shadow state; fills the report run,
    // returns its length (0 for commands that report nothing).
    function automatic int advance_joints(input t_cmd c, output t_report run [NUM_J]);
        int     n;
        longint nxt, step, lim;
        n = (lim_count == 0) ? 1 : ((lim_count > NUM_J) ? NUM_J : int'(lim_count));
        case (c.op)
            OP_TICK: begin
                lim = longint'(lim_step);
                for (int i = 0; i < n; i++) begin
                    if (jp_vel_mode) begin
                        // Q16.32 product, round half up, arithmetic shift = floor
                        nxt = longint'(jp_pos[i])
                            + ((longint'(jp_vel[i]) * longint'(c.et) + 32768) >>> 16);
                    end else begin
                        step = longint'(jp_goal[i]) - longint'(jp_pos[i]);
                        if (step > lim) step = lim;
                        if (step < -lim) step = -lim;
                        nxt = longint'(jp_pos[i]) + step;
                    end
                    jp_pos[i] = IO_VAL_W'(clamp_q16(nxt));
                end
            end
            OP_SET_GOAL: begin
                jp_goal[c.jnt] = c.val;
                jp_vel_mode    = 1'b0;
            end
            OP_SET_VEL: begin
                jp_vel[c.jnt] = c.val;
                jp_vel_mode   = 1'b1;
            end
            OP_PRESET: begin
                jp_pos[c.jnt]  = c.val;
                jp_goal[c.jnt] = c.val;
            end
            default: ;
        endcase
        if (c.op != OP_TICK && c.op != OP_READ) return 0;
        for (int i = 0; i < n; i++) begin
            run[i] = '{idx: JOINT_W'(i), pos: jp_pos[i], last: (i == n - 1)};
        end
        return n;
    endfunction

    // One input beat, with random idle ahead of it; queues what it reports.
    task automatic send_cmd(input t_cmd c, input logic pin,
                            input logic [JOINT_W-1:0] pin_jnt,
                            input logic [IO_VAL_W-1:0] pin_pos);
        t_report run [NUM_J];
        int      n;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {{TDATA_PAD{1'b0}}, c.et, c.val, c.jnt};
        do @(posedge i_clk); while (!s_axis_tready);
        n = advance_joints(c, run);
        if (pin) run[pin_jnt].pos = pin_pos;  // hand-typed value overrides
        for (int i = 0; i < n; i++) report_q.push_back(run[i]);
    endtask

    // Wait for the block to go quiet: every report in, then a full ring pass.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYC) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back cycles; block must be idle.
    task automatic load_limits(input logic [STEP_W-1:0] step, input logic [JIU_W-1:0] cnt);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_MAX_STEP;
        i_cfg_wdata <= step;
        @(posedge i_clk);
        lim_step     = step;
        i_cfg_addr  <= REG_JOINTS_IN_USE;
        i_cfg_wdata <= STEP_W'(cnt);
        @(posedge i_clk);
        lim_count    = cnt;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [IO_VAL_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return IO_VAL_W'($urandom);
            1: return IO_VAL_W'(int'($urandom_range(2 ** 21)) - 2 ** 20);
            2: begin
                case ($urandom_range(3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return IO_VAL_W'(int'($urandom_range(2 ** 27)) - 2 ** 26);
        endcase
    endfunction

    function automatic t_cmd pick_cmd();
        t_cmd c;
        int   roll;
        roll  = $urandom_range(99);
        c.jnt = JOINT_W'($urandom_range(NUM_J - 1));
        c.val = pick_value();
        c.et  = $urandom_range(1) ? ET_W'($urandom) : ET_W'($urandom_range(64));
        if (roll < 30)      c.op = OP_TICK;
        else if (roll < 40) c.op = OP_READ;
        else if (roll < 55) c.op = OP_SET_GOAL;
        else if (roll < 70) c.op = OP_SET_VEL;
        else if (roll < 92) c.op = OP_PRESET;
        else                c.op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
        return c;
    endfunction

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Output checker: each beat against the oldest queued report
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (report_q.size() == 0) begin
                $error("unexpected output beat: joint_index %0d position %h",
                       m_axis_tdata[2:0], m_axis_tdata[34:3]);
                n_fail++;
            end else begin
                want = report_q.pop_front();
                if (m_axis_tdata[2:0] !== want.idx) begin
                    $error("joint_index: expected %0d, got %0d", want.idx, m_axis_tdata[2:0]);
                    n_fail++;
                end
                if (m_axis_tdata[34:3] !== want.pos) begin
                    $error("position: expected %h, got %h", want.pos, m_axis_tdata[34:3]);
                    n_fail++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: any accepted beat or register write counts as progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Main sequence
    initial begin
        logic [STEP_W-1:0] step;
        logic [JIU_W-1:0]  cnt;

        for (int i = 0; i < NUM_J; i++) begin
            jp_pos[i]  = '0;
            jp_goal[i] = '0;
            jp_vel[i]  = '0;
        end
        jp_vel_mode = 1'b0;
        lim_step    = MAX_STEP_RST;
        lim_count   = JIU_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        foreach (DIR_ROWS[r]) begin
            if (DIR_ROWS[r].kind == ROW_LIMITS) begin
                settle();
                load_limits(DIR_ROWS[r].lim_step, DIR_ROWS[r].lim_count);
            end else begin
                send_cmd(DIR_ROWS[r].cmd, DIR_ROWS[r].pin,
                         DIR_ROWS[r].pin_jnt, DIR_ROWS[r].pin_pos);
            end
        end

        // random phases: limits change between phases, idling rotates
        for (int ph = 0; ph < N_PHASE; ph++) begin
            case (ph)
                0: begin step = '0;                            cnt = 4'd15;  end
                1: begin step = STEP_MAX;                      cnt = 4'd0;   end
                2: begin step = STEP_W'($urandom);             cnt = 4'd1;   end
                3: begin step = STEP_W'($urandom_range(2 ** 20)); cnt = 4'd8; end
                default: begin
                    step = $urandom_range(1) ? STEP_W'($urandom) : STEP_W'($urandom_range(4096));
                    cnt  = JIU_W'($urandom);
                end
            endcase
            settle();
            load_limits(step, cnt);
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
                default: begin src_idle_pct = 25; snk_stall_pct = 25; end
            endcase
            for (int k = 0; k < BEATS_PER_PHASE; k++) send_cmd(pick_cmd(), 1'b0, '0, '0);
        end

        settle();
        if (n_fail == 0 && report_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
